// ----- rtl/core/lsad_pkg.sv -----
// shared constants, types and state codes of the light slot table
`timescale 1ns / 1ps

package lsad_pkg;

  localparam int SLOTS = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  localparam int KEY_W = 16;
  localparam int EXP_W = 34;
  localparam int RAD_W = 20;
  localparam int DEC_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int OUT_SLOT_W = 5;
  localparam int PROD_W = TIME_W + DEC_W;

  localparam logic [RAD_W-1:0] RADIUS_MAX = '1;
  localparam logic [EXP_W-1:0] EXP_RETIRED = '1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic CFG_UPDATE_INTERVAL = 1'b0;
  localparam logic CFG_KILL_HOLD = 1'b1;

  localparam logic [CFG_W-1:0] UPDATE_INTERVAL_RST = 16'd28;
  localparam logic [CFG_W-1:0] KILL_HOLD_RST = 16'd1000;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [EXP_W-1:0]  expiry;
    logic [RAD_W-1:0]  radius;
    logic [DEC_W-1:0]  decay;
    logic [TIME_W-1:0] last_upd;
    logic              dirty;
    logic              kill;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_SCAN,
    ST_EXP_SCAN,
    ST_ALLOC_WR,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_WB
  } state_t;

endpackage

// ----- rtl/core/lsad_table.sv -----
// slot table memory with registered read and per-entry valid bits
`timescale 1ns / 1ps

module lsad_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [lsad_pkg::SLOT_W-1:0] rd_addr,
  output lsad_pkg::entry_t            rd_data,
  input  logic                        wr_en,
  input  logic [lsad_pkg::SLOT_W-1:0] wr_addr,
  input  lsad_pkg::entry_t            wr_data
);

  lsad_pkg::entry_t mem [lsad_pkg::SLOTS];
  logic [lsad_pkg::SLOTS-1:0] valid;
  lsad_pkg::entry_t rd_q;
  logic rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_hit ? rd_q : '0;

endmodule

// ----- rtl/core/light_slot_alloc_decay_top.sv -----
// top level of the timed light slot table with allocation and decay sweep
// usage:
//   input channel (in_valid/in_ready) takes one request item: req_type 0
//   allocates a slot, req_type 1 runs a decay tick over every slot
//   output channel (out_valid/out_ready) gives one item per allocation and
//   one item per slot for a tick, in slot order, last high on the final one
//   configuration: cfg_we writes cfg_data to register cfg_idx (0 update
//   interval, 1 kill hold) at once; write only while no request is open
//   timing: one request at a time, the table lives in a single-port-read
//   memory with one cycle read latency
//   allocation with a key: key scan up to SLOTS+1 cycles, then, if no key
//   matched, expiry scan up to SLOTS+1 cycles, then 1 write cycle
//   allocation without a key: expiry scan plus the write cycle
//   tick: 1 + 2*SLOTS cycles, two per slot for read-modify-write through
//   the decay multiplier
//   a full output register stalls the block until the receiver takes it
//   reset: synchronous, clears valid bits so every slot reads as zero at
//   once, no clearing pass; registers return to 28 and 1000
`timescale 1ns / 1ps

module light_slot_alloc_decay_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] light_id,
  input  logic [31:0] now,
  input  logic [19:0] radius_in,
  input  logic [15:0] lifetime,
  input  logic [15:0] decay_in,
  input  logic        kill_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  slot,
  output logic [19:0] radius_out,
  output logic        dirty_out,
  output logic        live_out,
  output logic        last
);

  localparam int SW = lsad_pkg::SLOT_W;
  localparam int CW = lsad_pkg::CNT_W;
  localparam int EW = lsad_pkg::EXP_W;

  lsad_pkg::state_t state, state_next;

  logic [15:0] update_interval, kill_hold;

  logic                         r_req;
  logic [lsad_pkg::KEY_W-1:0]   r_key;
  logic [lsad_pkg::TIME_W-1:0]  r_now;
  logic [lsad_pkg::RAD_W-1:0]   r_rad;
  logic [15:0]                  r_life;
  logic [lsad_pkg::DEC_W-1:0]   r_dec;
  logic                         r_kill;

  logic [CW-1:0] cnt, cnt_next;
  logic          chk_vld, chk_vld_next;
  logic [SW-1:0] chk_idx, chk_idx_next;
  logic [SW-1:0] low_idx, low_idx_next;
  logic [EW-1:0] low_exp, low_exp_next;
  logic [SW-1:0] sel, sel_next;

  lsad_pkg::entry_t ev_entry;
  logic [EW-1:0] ev_exp;
  logic ev_active, ev_due;
  logic [lsad_pkg::PROD_W-1:0] ev_prod;

  logic tb_rd_en, tb_wr_en;
  logic [SW-1:0] tb_rd_addr, tb_wr_addr;
  lsad_pkg::entry_t tb_rd_data, tb_wr_data;

  logic out_load;
  logic [4:0] slot_next;
  logic [19:0] radius_out_next;
  logic dirty_out_next, live_out_next, last_next;

  logic [EW-1:0] now_x;
  logic [EW-1:0] exp_eval;
  logic [lsad_pkg::TIME_W:0] due_time;
  logic [lsad_pkg::TIME_W-1:0] elapsed;
  logic active_eval, due_eval;
  logic [lsad_pkg::PROD_W-1:0] prod_eval;
  logic [lsad_pkg::RAD_W-1:0] prod_sat;
  lsad_pkg::entry_t wb_entry;
  logic out_free;
  logic low_take;
  logic [SW-1:0] low_idx_eff;

  lsad_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tb_rd_en),
    .rd_addr (tb_rd_addr),
    .rd_data (tb_rd_data),
    .wr_en   (tb_wr_en),
    .wr_addr (tb_wr_addr),
    .wr_data (tb_wr_data)
  );

  assign in_ready = (state == lsad_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign now_x = {2'b00, r_now};

  // tick evaluation of the entry just read
  always_comb begin
    exp_eval = tb_rd_data.kill ? (now_x + EW'(kill_hold)) : tb_rd_data.expiry;
    active_eval = !($signed(exp_eval) < $signed(now_x)) && (tb_rd_data.radius != '0);
    due_time = {1'b0, tb_rd_data.last_upd} + (lsad_pkg::TIME_W + 1)'(update_interval);
    due_eval = ({1'b0, r_now} >= due_time);
    elapsed = r_now - tb_rd_data.last_upd;
    prod_eval = lsad_pkg::PROD_W'(elapsed) * lsad_pkg::PROD_W'(tb_rd_data.decay);
  end

  // tick write-back of the evaluated entry
  always_comb begin
    prod_sat = (|ev_prod[lsad_pkg::PROD_W-1:lsad_pkg::RAD_W]) ? lsad_pkg::RADIUS_MAX
                                                             : ev_prod[lsad_pkg::RAD_W-1:0];
    wb_entry = ev_entry;
    wb_entry.expiry = ev_exp;
    if (ev_active) begin
      if (ev_due) begin
        wb_entry.dirty = 1'b1;
        wb_entry.last_upd = r_now;
        if ((prod_sat > ev_entry.radius) || ev_entry.kill) begin
          wb_entry.kill = 1'b0;
          wb_entry.radius = '0;
          wb_entry.expiry = lsad_pkg::EXP_RETIRED;
        end else begin
          wb_entry.radius = ev_entry.radius - prod_sat;
        end
      end else begin
        wb_entry.dirty = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    chk_vld_next = chk_vld;
    chk_idx_next = chk_idx;
    low_idx_next = low_idx;
    low_exp_next = low_exp;
    sel_next = sel;
    tb_rd_en = 1'b0;
    tb_rd_addr = sel;
    tb_wr_en = 1'b0;
    tb_wr_addr = sel;
    tb_wr_data = wb_entry;
    out_load = 1'b0;
    slot_next = 5'(sel);
    radius_out_next = wb_entry.radius;
    dirty_out_next = wb_entry.dirty;
    live_out_next = !($signed(wb_entry.expiry) < $signed(now_x)) && (wb_entry.radius != '0);
    last_next = (sel == lsad_pkg::LAST_IDX);
    low_take = (chk_idx == '0) || ($signed(tb_rd_data.expiry) < $signed(low_exp));
    low_idx_eff = low_take ? chk_idx : low_idx;

    case (state)
      lsad_pkg::ST_IDLE: begin
        cnt_next = '0;
        chk_vld_next = 1'b0;
        sel_next = '0;
        if (in_valid) begin
          if (req_type == lsad_pkg::REQ_TICK) begin
            state_next = lsad_pkg::ST_TICK_RD;
          end else if (light_id != '0) begin
            state_next = lsad_pkg::ST_KEY_SCAN;
          end else begin
            state_next = lsad_pkg::ST_EXP_SCAN;
          end
        end
      end

      lsad_pkg::ST_KEY_SCAN, lsad_pkg::ST_EXP_SCAN: begin
        if (cnt != CW'(lsad_pkg::SLOTS)) begin
          tb_rd_en = 1'b1;
          tb_rd_addr = cnt[SW-1:0];
          cnt_next = cnt + CW'(1);
          chk_vld_next = 1'b1;
          chk_idx_next = cnt[SW-1:0];
        end else begin
          chk_vld_next = 1'b0;
        end
        if (chk_vld) begin
          if (state == lsad_pkg::ST_KEY_SCAN) begin
            if (tb_rd_data.key == r_key) begin
              sel_next = chk_idx;
              state_next = lsad_pkg::ST_ALLOC_WR;
            end else if (chk_idx == lsad_pkg::LAST_IDX) begin
              cnt_next = '0;
              chk_vld_next = 1'b0;
              state_next = lsad_pkg::ST_EXP_SCAN;
            end
          end else begin
            if (low_take) begin
              low_idx_next = chk_idx;
              low_exp_next = tb_rd_data.expiry;
            end
            if ($signed(tb_rd_data.expiry) < $signed(now_x)) begin
              sel_next = chk_idx;
              state_next = lsad_pkg::ST_ALLOC_WR;
            end else if (chk_idx == lsad_pkg::LAST_IDX) begin
              sel_next = low_idx_eff;
              state_next = lsad_pkg::ST_ALLOC_WR;
            end
          end
        end
      end

      lsad_pkg::ST_ALLOC_WR: begin
        tb_wr_data.key = r_key;
        tb_wr_data.expiry = now_x + EW'(r_life);
        tb_wr_data.radius = r_rad;
        tb_wr_data.decay = r_dec;
        tb_wr_data.last_upd = r_now;
        tb_wr_data.dirty = 1'b1;
        tb_wr_data.kill = r_kill;
        radius_out_next = r_rad;
        dirty_out_next = 1'b1;
        live_out_next = (r_rad != '0);
        last_next = 1'b1;
        if (out_free) begin
          tb_wr_en = 1'b1;
          out_load = 1'b1;
          state_next = lsad_pkg::ST_IDLE;
        end
      end

      lsad_pkg::ST_TICK_RD: begin
        tb_rd_en = 1'b1;
        state_next = lsad_pkg::ST_TICK_EV;
      end

      lsad_pkg::ST_TICK_EV: begin
        state_next = lsad_pkg::ST_TICK_WB;
      end

      lsad_pkg::ST_TICK_WB: begin
        if (out_free) begin
          tb_wr_en = 1'b1;
          out_load = 1'b1;
          if (sel == lsad_pkg::LAST_IDX) begin
            state_next = lsad_pkg::ST_IDLE;
          end else begin
            // next slot read overlaps this write, different entry
            sel_next = sel + SW'(1);
            tb_rd_en = 1'b1;
            tb_rd_addr = sel + SW'(1);
            state_next = lsad_pkg::ST_TICK_EV;
          end
        end
      end

      default: begin
        state_next = lsad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsad_pkg::ST_IDLE;
      update_interval <= lsad_pkg::UPDATE_INTERVAL_RST;
      kill_hold <= lsad_pkg::KILL_HOLD_RST;
      out_valid <= 1'b0;
      cnt <= '0;
      chk_vld <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      chk_vld <= chk_vld_next;
      if (cfg_we) begin
        case (cfg_idx)
          lsad_pkg::CFG_UPDATE_INTERVAL: update_interval <= cfg_data;
          lsad_pkg::CFG_KILL_HOLD: kill_hold <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= chk_idx_next;
    low_idx <= low_idx_next;
    low_exp <= low_exp_next;
    sel <= sel_next;
    if (in_valid && in_ready) begin
      r_req <= req_type;
      r_key <= light_id;
      r_now <= now;
      r_rad <= radius_in;
      r_life <= lifetime;
      r_dec <= decay_in;
      r_kill <= kill_in;
    end
    if (state == lsad_pkg::ST_TICK_EV && r_req == lsad_pkg::REQ_TICK) begin
      ev_entry <= tb_rd_data;
      ev_exp <= exp_eval;
      ev_active <= active_eval;
      ev_due <= due_eval;
      ev_prod <= prod_eval;
    end
    if (out_load) begin
      slot <= slot_next;
      radius_out <= radius_out_next;
      dirty_out <= dirty_out_next;
      live_out <= live_out_next;
      last <= last_next;
    end
  end

endmodule

// ----- dv/light_slot_checker.sv -----
// checker for the light slot table: predicts each slot report and compares it with the block
`timescale 1ns / 1ps

module light_slot_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] light_id,
  input  logic [31:0] now,
  input  logic [19:0] radius_in,
  input  logic [15:0] lifetime,
  input  logic [15:0] decay_in,
  input  logic        kill_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  slot,
  input  logic [19:0] radius_out,
  input  logic        dirty_out,
  input  logic        live_out,
  input  logic        last,
  output int          mismatches,
  output int          outstanding,
  output int          reports_checked
);

  localparam longint EXPIRY_RETIRED = -1;
  localparam int SLOTS = lsad_pkg::SLOTS;
  localparam int OUT_SLOT_W = lsad_pkg::OUT_SLOT_W;
  localparam int RAD_W = lsad_pkg::RAD_W;
  localparam int KEY_W = lsad_pkg::KEY_W;
  localparam int DEC_W = lsad_pkg::DEC_W;
  localparam int TIME_W = lsad_pkg::TIME_W;
  localparam int CFG_W = lsad_pkg::CFG_W;

  typedef struct {
    logic [OUT_SLOT_W-1:0] slot;
    logic [RAD_W-1:0]      radius;
    logic                  dirty;
    logic                  live;
    logic                  last;
  } slot_report_t;

  logic [CFG_W-1:0]  interval_reg;
  logic [CFG_W-1:0]  hold_reg;
  logic [KEY_W-1:0]  key_tab [SLOTS];
  longint            expiry_tab [SLOTS];
  logic [RAD_W-1:0]  radius_tab [SLOTS];
  logic [DEC_W-1:0]  decay_tab [SLOTS];
  logic [TIME_W-1:0] upd_tab [SLOTS];
  logic              dirty_tab [SLOTS];
  logic              kill_tab [SLOTS];
  slot_report_t      expected_reports [$];
  int                errs;
  int                checked;

  function automatic slot_report_t slot_report(int s, logic [TIME_W-1:0] t, logic fin);
    slot_report_t r;
    r.slot = OUT_SLOT_W'(s);
    r.radius = radius_tab[s];
    r.dirty = dirty_tab[s];
    r.live = (expiry_tab[s] >= longint'(t)) && (radius_tab[s] != '0);
    r.last = fin;
    return r;
  endfunction

  // appends one expected report at the tail
  function automatic void queue_report(slot_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  // key match first, then first expired slot, else earliest expiry
  function automatic int pick_slot(logic [KEY_W-1:0] key, logic [TIME_W-1:0] t);
    int oldest = 0;
    if (key != '0) begin
      for (int i = 0; i < SLOTS; i++)
        if (key_tab[i] == key) return i;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (expiry_tab[i] < expiry_tab[oldest]) oldest = i;
      if (expiry_tab[i] < longint'(t)) return i;
    end
    return oldest;
  endfunction

  task automatic predict_alloc(logic [KEY_W-1:0] key, logic [TIME_W-1:0] t,
                               logic [RAD_W-1:0] rad, logic [15:0] life,
                               logic [DEC_W-1:0] dec, logic kil);
    int s;
    s = pick_slot(key, t);
    key_tab[s] = key;
    radius_tab[s] = rad;
    decay_tab[s] = dec;
    expiry_tab[s] = longint'(t) + longint'(life);
    kill_tab[s] = kil;
    upd_tab[s] = t;
    dirty_tab[s] = 1'b1;
    queue_report(slot_report(s, t, 1'b1));
  endtask

  task automatic predict_sweep(logic [TIME_W-1:0] t);
    logic [63:0] due;
    logic [63:0] span;
    logic [63:0] loss;
    for (int i = 0; i < SLOTS; i++) begin
      if (kill_tab[i]) expiry_tab[i] = longint'(t) + longint'(hold_reg);
      if (!(expiry_tab[i] < longint'(t) || radius_tab[i] == '0)) begin
        due = 64'(upd_tab[i]) + 64'(interval_reg);
        if (64'(t) >= due) begin
          span = 64'(t) - 64'(upd_tab[i]);
          loss = span * 64'(decay_tab[i]);
          if (loss > 64'(lsad_pkg::RADIUS_MAX)) loss = 64'(lsad_pkg::RADIUS_MAX);
          dirty_tab[i] = 1'b1;
          upd_tab[i] = t;
          if (loss > 64'(radius_tab[i]) || kill_tab[i]) begin
            kill_tab[i] = 1'b0;
            radius_tab[i] = '0;
            expiry_tab[i] = EXPIRY_RETIRED;
          end else begin
            radius_tab[i] = radius_tab[i] - RAD_W'(loss);
          end
        end else begin
          dirty_tab[i] = 1'b0;
        end
      end
      queue_report(slot_report(i, t, i == SLOTS - 1));
    end
  endtask

  function automatic int field_diff(string name, logic [OUT_SLOT_W-1:0] at,
                                    logic [RAD_W-1:0] exp_v, logic [RAD_W-1:0] got_v);
    if (got_v === exp_v) return 0;
    $display("%0t: %s of slot %0d: expected %0h, got %0h", $time, name, at, exp_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    slot_report_t want;
    if (rst) begin
      interval_reg = lsad_pkg::UPDATE_INTERVAL_RST;
      hold_reg = lsad_pkg::KILL_HOLD_RST;
      for (int i = 0; i < SLOTS; i++) begin
        key_tab[i] = '0;
        expiry_tab[i] = 0;
        radius_tab[i] = '0;
        decay_tab[i] = '0;
        upd_tab[i] = '0;
        dirty_tab[i] = 1'b0;
        kill_tab[i] = 1'b0;
      end
      expected_reports.delete();
      errs = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == lsad_pkg::CFG_UPDATE_INTERVAL) interval_reg = cfg_data;
        else hold_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        checked++;
        if (expected_reports.size() == 0) begin
          errs++;
          $display("%0t: slot report with none expected: expected nothing, got slot %0d radius %0h",
                   $time, slot, radius_out);
        end else begin
          want = expected_reports.pop_front();
          errs += field_diff("slot", want.slot, want.slot, slot);
          errs += field_diff("radius", want.slot, want.radius, radius_out);
          errs += field_diff("dirty", want.slot, want.dirty, dirty_out);
          errs += field_diff("live", want.slot, want.live, live_out);
          errs += field_diff("last", want.slot, want.last, last);
        end
      end
      if (in_valid && in_ready) begin
        if (req_type == lsad_pkg::REQ_TICK) predict_sweep(now);
        else predict_alloc(light_id, now, radius_in, lifetime, decay_in, kill_in);
      end
    end
    mismatches <= errs;
    outstanding <= expected_reports.size();
    reports_checked <= checked;
  end

endmodule

// ----- dv/tb_light_slot_alloc_decay_top.sv -----
// testbench top for the light slot table: drives requests and registers, gives the verdict
`timescale 1ns / 1ps

module tb_light_slot_alloc_decay_top;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_OFF_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = lsad_pkg::CFG_UPDATE_INTERVAL;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = lsad_pkg::REQ_ALLOC;
  logic [15:0] light_id = '0;
  logic [31:0] now = '0;
  logic [19:0] radius_in = '0;
  logic [15:0] lifetime = '0;
  logic [15:0] decay_in = '0;
  logic        kill_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  slot;
  logic [19:0] radius_out;
  logic        dirty_out;
  logic        live_out;
  logic        last;

  int          mismatches;
  int          outstanding;
  int          reports_checked;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          idle_cycles = 0;
  int          allocs_sent = 0;
  int          sweeps_sent = 0;
  logic [31:0] time_base = 32'd1000;

  light_slot_alloc_decay_top u_dut (.*);

  light_slot_checker u_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("light_slot_alloc_decay_top regression: fail");
    $finish;
  end

  task automatic send_request(logic op, logic [15:0] id, logic [31:0] t, logic [19:0] rad,
                              logic [15:0] life, logic [15:0] dec, logic kil);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= op;
    light_id <= id;
    now <= t;
    radius_in <= rad;
    lifetime <= life;
    decay_in <= dec;
    kill_in <= kil;
    do @(posedge clk); while (!in_ready);
    if (op == lsad_pkg::REQ_TICK) sweeps_sent++;
    else allocs_sent++;
  endtask

  // mostly advancing time over a small key pool, with some jumps and full-range values
  task automatic send_random();
    logic        op;
    logic [15:0] id;
    logic [31:0] t;
    logic [19:0] rad;
    logic [15:0] life;
    logic [15:0] dec;
    logic        kil;
    int          roll;
    op = ($urandom_range(99) < 22) ? lsad_pkg::REQ_TICK : lsad_pkg::REQ_ALLOC;
    roll = $urandom_range(99);
    if (roll < 85) begin
      if ($urandom_range(99) >= 30) time_base += $urandom_range(1, 60);
      t = time_base;
    end else if (roll < 92) begin
      t = time_base - $urandom_range(1, 200);
    end else begin
      t = $urandom();
    end
    roll = $urandom_range(99);
    if (roll < 70) id = 16'($urandom_range(1, 40));
    else if (roll < 85) id = '0;
    else id = 16'($urandom_range(0, 65535));
    roll = $urandom_range(99);
    if (roll < 80) rad = 20'($urandom_range(256, 65535));
    else if (roll < 90) rad = 20'($urandom());
    else if (roll < 95) rad = '0;
    else rad = lsad_pkg::RADIUS_MAX;
    roll = $urandom_range(99);
    if (roll < 55) life = 16'($urandom_range(100, 3000));
    else if (roll < 80) life = 16'd2000;
    else life = 16'($urandom_range(0, 65535));
    if ($urandom_range(99) < 75) dec = 16'($urandom_range(0, 40));
    else dec = 16'($urandom_range(0, 65535));
    kil = ($urandom_range(99) < 15);
    send_request(op, id, t, rad, life, dec, kil);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(logic [15:0] interval, logic [15:0] hold);
    cfg_we <= 1'b1;
    cfg_idx <= lsad_pkg::CFG_UPDATE_INTERVAL;
    cfg_data <= interval;
    @(posedge clk);
    cfg_idx <= lsad_pkg::CFG_KILL_HOLD;
    cfg_data <= hold;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int items, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_random();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: key reuse, first expired, decay, saturation, kill, time going back
    send_request(lsad_pkg::REQ_ALLOC, 16'd1, 32'd100, 20'h01000, 16'd500, 16'd1, 1'b0);
    send_request(lsad_pkg::REQ_ALLOC, 16'hFFFF, 32'd100, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(lsad_pkg::REQ_ALLOC, 16'd3, 32'd100, 20'h00800, 16'd1000, 16'h0010, 1'b1);
    send_request(lsad_pkg::REQ_ALLOC, 16'd1, 32'd110, 20'h02000, 16'd400, 16'd2, 1'b0);
    send_request(lsad_pkg::REQ_ALLOC, 16'd0, 32'd120, 20'h00000, 16'd0, 16'd0, 1'b0);
    send_request(lsad_pkg::REQ_TICK, 16'd0, 32'd120, 20'h00000, 16'd0, 16'd0, 1'b0);
    send_request(lsad_pkg::REQ_TICK, 16'd0, 32'd200, 20'h00000, 16'd0, 16'd0, 1'b0);
    send_request(lsad_pkg::REQ_TICK, 16'd0, 32'd150, 20'h00000, 16'd0, 16'd0, 1'b0);
    send_request(lsad_pkg::REQ_ALLOC, 16'd0, 32'd0, 20'h00100, 16'd50, 16'd3, 1'b0);
    send_request(lsad_pkg::REQ_ALLOC, 16'd0, 32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF, 16'd0, 1'b1);
    send_request(lsad_pkg::REQ_TICK, 16'hFFFF, 32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF,
                 1'b1);
    send_request(lsad_pkg::REQ_TICK, 16'd0, 32'd0, 20'h00000, 16'd0, 16'd0, 1'b0);
    send_request(lsad_pkg::REQ_ALLOC, 16'd5, 32'd300, 20'h00064, 16'd0, 16'hFFFF, 1'b0);
    send_request(lsad_pkg::REQ_TICK, 16'd0, 32'd301, 20'h00000, 16'd0, 16'd0, 1'b0);
    send_request(lsad_pkg::REQ_ALLOC, 16'd6, 32'd400, 20'h00070, 16'd1000, 16'd4, 1'b0);
    send_request(lsad_pkg::REQ_TICK, 16'd0, 32'd428, 20'h00000, 16'd0, 16'd0, 1'b0);
    send_request(lsad_pkg::REQ_TICK, 16'd0, 32'd500, 20'h00000, 16'd0, 16'd0, 1'b0);
    drain();

    set_registers(16'd0, 16'd0);
    random_phase(70, 0, 0);
    drain();

    set_registers(16'hFFFF, 16'hFFFF);
    random_phase(50, 66, 0);
    drain();

    set_registers(16'($urandom_range(0, 64)), 16'($urandom_range(0, 65535)));
    random_phase(50, 0, 66);
    drain();

    set_registers(16'd1, 16'($urandom_range(0, 65535)));
    random_phase(50, 22, 22);
    drain();

    // receiver holds off while requests keep coming, so the block backs up
    hold_cycles = HOLD_OFF_CYCLES;
    random_phase(30, 0, 0);

    recv_stall_pct = 0;
    drain();

    $display("sent %0d allocations and %0d decay sweeps, %0d slot reports compared",
             allocs_sent, sweeps_sent, reports_checked);
    $display("register extremes, sender gaps, receiver stalls and a long hold-off were covered");
    if (mismatches == 0) begin
      $display("light_slot_alloc_decay_top regression: pass");
    end else begin
      $display("light_slot_alloc_decay_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lsad_pkg.sv
rtl/core/lsad_table.sv
rtl/core/light_slot_alloc_decay_top.sv
dv/light_slot_checker.sv
dv/tb_light_slot_alloc_decay_top.sv
